@@ sv/piaw_pkg.sv @@
package piaw_pkg;

  localparam int REG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX    = 3'd3;

  localparam logic [REG_W-1:0] OUT_MIN_RST = 24'h800000;
  localparam logic [REG_W-1:0] OUT_MAX_RST = 24'h7FFFFF;

endpackage

@@ sv/pi_controller_trapezoid_antiwindup.sv @@
// A request passes the stage 1, stage 2 and output registers in that order. Throughput: one
// request per cycle while out_stall does not hold the pipeline; the integrator and hold flag
// close their loop in the output stage; the two gain multiplies have a stage of their own.
// Reset (synchronous, active low) empties the pipeline, clears the integrator,
// previous error and hold flag, and returns the gain and limit registers to their defaults.
module pi_controller_trapezoid_antiwindup #(
  parameter int ERROR_WIDTH    = 16,
  parameter int OUT_WIDTH      = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [piaw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [piaw_pkg::REG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ERROR_WIDTH-1:0]        in_error_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [OUT_WIDTH-1:0]          out_drive_value,
  output logic                                 out_saturated
);

  import piaw_pkg::*;

  localparam int EW  = ERROR_WIDTH;
  localparam int OW  = OUT_WIDTH;
  localparam int EW1 = EW + 1;
  localparam int OW1 = OW + 1;
  localparam int PW  = EW1 + REG_W + 1;
  localparam int SW  = (PW > OW) ? PW : OW;

  localparam logic signed [SW-1:0] OMAX = {{(SW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [SW-1:0] OMIN = ~OMAX;

  function automatic logic signed [OW-1:0] sat_ow(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] t;
    t = x;
    if (t > OMAX) t = OMAX;
    if (t < OMIN) t = OMIN;
    return t[OW-1:0];
  endfunction

  function automatic logic signed [OW-1:0] clamp_lim(input logic signed [OW:0] x,
                                                     input logic signed [OW-1:0] lo,
                                                     input logic signed [OW-1:0] hi);
    logic signed [OW:0] t;
    t = x;
    if (t > OW1'(hi)) t = OW1'(hi);
    if (t < OW1'(lo)) t = OW1'(lo);
    return t[OW-1:0];
  endfunction

  logic [REG_W-1:0]          kp_r;
  logic [REG_W-1:0]          ki_r;
  logic signed [OW-1:0]      lim_lo_r;
  logic signed [OW-1:0]      lim_hi_r;

  logic signed [EW-1:0]      prev_err_r;
  logic                      s1_valid_r;
  logic signed [EW-1:0]      s1_err_r;
  logic signed [EW:0]        s1_esum_r;

  logic                      s2_valid_r;
  logic signed [OW-1:0]      s2_p_r;
  logic signed [OW-1:0]      s2_d_r;

  logic                      out_valid_r;
  logic signed [OW-1:0]      out_drive_r;
  logic                      out_sat_r;
  logic signed [OW-1:0]      integ_r;
  logic                      hold_r;

  logic                      out_free;
  logic                      s2_free;
  logic                      s1_free;
  logic                      s2_adv;
  logic                      s1_adv;
  logic                      in_acc;

  logic signed [PW-1:0]      p_prod;
  logic signed [PW-1:0]      d_prod;
  logic signed [OW-1:0]      s2_p_nxt;
  logic signed [OW-1:0]      s2_d_nxt;

  logic signed [OW-1:0]      d_sel;
  logic signed [OW:0]        integ_sum;
  logic signed [OW-1:0]      integ_nxt;
  logic signed [OW:0]        drive_sum;
  logic signed [OW-1:0]      out_drive_nxt;
  logic                      out_sat_nxt;

  // Each stage moves on when the stage after it is empty or moving too.
  assign out_free = !out_valid_r || !out_stall;
  assign s2_adv   = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_adv   = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;
  assign in_acc   = in_valid && s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= '0;
      ki_r     <= '0;
      lim_lo_r <= sat_ow(SW'($signed(OUT_MIN_RST)));
      lim_hi_r <= sat_ow(SW'($signed(OUT_MAX_RST)));
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_KP_GAIN:    kp_r     <= cfg_data;
        CFG_INTEG_GAIN: ki_r     <= cfg_data;
        CFG_OUT_MIN:    lim_lo_r <= sat_ow(SW'($signed(cfg_data)));
        CFG_OUT_MAX:    lim_hi_r <= sat_ow(SW'($signed(cfg_data)));
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      prev_err_r <= '0;
    end else begin
      if (in_acc) begin
        prev_err_r <= in_error_sample;
      end
      if (s1_free) begin
        s1_valid_r <= in_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_err_r  <= in_error_sample;
      s1_esum_r <= EW1'(in_error_sample) + EW1'(prev_err_r);
    end
  end

  // Products floor toward minus infinity through the arithmetic shift.
  assign p_prod   = PW'(s1_err_r) * PW'($signed({1'b0, kp_r}));
  assign d_prod   = PW'(s1_esum_r) * PW'($signed({1'b0, ki_r}));
  assign s2_p_nxt = sat_ow(SW'(p_prod >>> GAIN_FRAC_BITS));
  assign s2_d_nxt = sat_ow(SW'(d_prod >>> GAIN_FRAC_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_p_r <= s2_p_nxt;
      s2_d_r <= s2_d_nxt;
    end
  end

  // The integrator is held for one request after the output has been clamped.
  assign d_sel         = hold_r ? '0 : s2_d_r;
  assign integ_sum     = OW1'(integ_r) + OW1'(d_sel);
  assign integ_nxt     = clamp_lim(integ_sum, lim_lo_r, lim_hi_r);
  assign drive_sum     = OW1'(s2_p_r) + OW1'(integ_nxt);
  assign out_drive_nxt = clamp_lim(drive_sum, lim_lo_r, lim_hi_r);
  assign out_sat_nxt   = (OW1'(out_drive_nxt) != drive_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_sat_r   <= 1'b0;
      integ_r     <= '0;
      hold_r      <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= s2_adv;
      end
      if (s2_adv) begin
        out_sat_r <= out_sat_nxt;
        integ_r   <= integ_nxt;
        hold_r    <= out_sat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_drive_r <= out_drive_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_value = out_drive_r;
  assign out_saturated   = out_sat_r;

  a_hold_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sat_r == hold_r))
    else $error("hold flag differs from the last saturation flag");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input not stalled with a full stalled pipeline");

endmodule
